@@ src/ulp_error_statistics_defines.svh @@
// assertion macros for the ulp error statistics block
// used by the top level only, no other dependencies
`ifndef ULP_ERROR_STATISTICS_DEFINES_SVH
`define ULP_ERROR_STATISTICS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ULPES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ULPES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ulpes_pkg.sv @@
// shared types, constants and a helper function of the ulp error statistics block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ulpes_pkg;

    localparam int DEF_COUNT_BITS = 48;
    localparam int DEF_HIST_BINS  = 16;
    localparam int OUT_CNT_W      = 48;
    localparam int GAP_W          = 64;
    localparam int BIN_NUM_W      = 5;

    localparam logic REQ_COMPARE = 1'b0;
    localparam logic REQ_FINISH  = 1'b1;

    localparam logic [GAP_W-1:0] SIGN_BIT = {1'b1, {(GAP_W-1){1'b0}}};

    typedef struct packed {
        logic             req_type;
        logic [GAP_W-1:0] want_bits;
        logic [GAP_W-1:0] got_bits;
    } t_in_word;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] pair_total;
        logic [OUT_CNT_W-1:0] mismatch_total;
        logic [GAP_W-1:0]     largest_gap;
        logic [GAP_W-1:0]     gap_sum;
        logic [BIN_NUM_W-1:0] bin_number;
        logic [OUT_CNT_W-1:0] bin_total;
        logic                 final_result;
    } t_out_word;

    // one item leaving the gap pipeline
    typedef struct packed {
        logic             vld;
        logic             fin;
        logic             mism;
        logic [GAP_W-1:0] gap;
    } t_gap_item;

    // totals frozen at a finish
    typedef struct packed {
        logic [OUT_CNT_W-1:0] pair_total;
        logic [OUT_CNT_W-1:0] mismatch_total;
        logic [GAP_W-1:0]     largest_gap;
        logic [GAP_W-1:0]     gap_sum;
    } t_totals;

    // monotone mapping, -0 and +0 both land on 2^63
    function automatic logic [GAP_W-1:0] order_key(input logic [GAP_W-1:0] bits);
        logic [GAP_W-1:0] key;
        if (bits[GAP_W-1]) begin
            key = ~bits + GAP_W'(1);
        end else begin
            key = bits ^ SIGN_BIT;
        end
        return key;
    endfunction

endpackage

`default_nettype wire

@@ src/ulpes_if.sv @@
// valid/ready channel interfaces for request and report words
// depends on ulpes_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ulpes_in_if import ulpes_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface ulpes_out_if import ulpes_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ src/ulpes_gap_pipe.sv @@
// input register, key mapping and ulp gap stages
// depends on ulpes_pkg and ulpes_if
`timescale 1ns / 1ps
`default_nettype none

module ulpes_gap_pipe import ulpes_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ulpes_in_if.sink   i_req,
    input  wire        i_hold,
    output t_gap_item  o_item
);

    logic             adv;
    logic             r_s1_vld;
    t_in_word         r_s1;
    logic             r_s2_vld;
    logic             r_s2_fin;
    logic             r_s2_eq;
    logic [GAP_W-1:0] r_s2_ka;
    logic [GAP_W-1:0] r_s2_kb;
    logic             r_s3_vld;
    logic             r_s3_fin;
    logic             r_s3_mism;
    logic [GAP_W-1:0] r_s3_gap;
    logic [GAP_W:0]   d_ab;
    logic [GAP_W:0]   d_ba;

    assign adv         = !i_hold;
    assign i_req.ready = adv;

    assign d_ab = {1'b0, r_s2_ka} - {1'b0, r_s2_kb};
    assign d_ba = {1'b0, r_s2_kb} - {1'b0, r_s2_ka};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= i_req.word;
            r_s2_fin  <= (r_s1.req_type == REQ_FINISH);
            r_s2_eq   <= (r_s1.want_bits == r_s1.got_bits);
            r_s2_ka   <= order_key(r_s1.want_bits);
            r_s2_kb   <= order_key(r_s1.got_bits);
            r_s3_fin  <= r_s2_fin;
            r_s3_mism <= !r_s2_eq;
            r_s3_gap  <= d_ab[GAP_W] ? d_ba[GAP_W-1:0] : d_ab[GAP_W-1:0];
        end
    end

    always_comb begin
        o_item.vld  = r_s3_vld;
        o_item.fin  = r_s3_fin;
        o_item.mism = r_s3_mism;
        o_item.gap  = r_s3_gap;
    end

endmodule

`default_nettype wire

@@ src/ulpes_accum.sv @@
// live statistics: counters, largest gap, gap sum and histogram lanes
// depends on ulpes_pkg
`timescale 1ns / 1ps
`default_nettype none

module ulpes_accum import ulpes_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int HIST_BINS  = DEF_HIST_BINS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_take,
    input  t_gap_item             i_item,
    output t_totals               o_tot,
    output logic [OUT_CNT_W-1:0]  o_hist [HIST_BINS]
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_pair, n_pair;
    logic [COUNT_BITS-1:0] r_mism, n_mism;
    logic [GAP_W-1:0]      r_max, n_max;
    logic [GAP_W-1:0]      r_sum, n_sum;
    logic [COUNT_BITS-1:0] r_lane [HIST_BINS];
    logic [COUNT_BITS-1:0] n_lane [HIST_BINS];
    logic [GAP_W:0]        sum_ext;
    logic                  cmp;
    logic                  hit;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    assign sum_ext = {1'b0, r_sum} + {1'b0, i_item.gap};
    assign cmp     = i_take && !i_item.fin;
    assign hit     = cmp && i_item.mism;

    always_comb begin
        n_pair = r_pair;
        n_mism = r_mism;
        n_max  = r_max;
        n_sum  = r_sum;
        for (int k = 0; k < HIST_BINS; k++) begin
            n_lane[k] = r_lane[k];
        end
        if (i_take && i_item.fin) begin
            // finish: totals were frozen by the reporter this cycle
            n_pair = '0;
            n_mism = '0;
            n_max  = '0;
            n_sum  = '0;
            for (int k = 0; k < HIST_BINS; k++) begin
                n_lane[k] = '0;
            end
        end else if (cmp) begin
            n_pair = sat_inc(r_pair);
            if (hit) begin
                n_mism = sat_inc(r_mism);
                if (i_item.gap > r_max) begin
                    n_max = i_item.gap;
                end
                n_sum = sum_ext[GAP_W] ? '1 : sum_ext[GAP_W-1:0];
                // a signed-zero mismatch has gap zero and matches no lane
                for (int k = 0; k < HIST_BINS - 1; k++) begin
                    if (i_item.gap == GAP_W'(k + 1)) begin
                        n_lane[k] = sat_inc(r_lane[k]);
                    end
                end
                if (i_item.gap >= GAP_W'(HIST_BINS)) begin
                    n_lane[HIST_BINS-1] = sat_inc(r_lane[HIST_BINS-1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= '0;
            r_mism <= '0;
            r_max  <= '0;
            r_sum  <= '0;
            for (int k = 0; k < HIST_BINS; k++) begin
                r_lane[k] <= '0;
            end
        end else begin
            r_pair <= n_pair;
            r_mism <= n_mism;
            r_max  <= n_max;
            r_sum  <= n_sum;
            for (int k = 0; k < HIST_BINS; k++) begin
                r_lane[k] <= n_lane[k];
            end
        end
    end

    always_comb begin
        o_tot.pair_total     = OUT_CNT_W'(r_pair);
        o_tot.mismatch_total = OUT_CNT_W'(r_mism);
        o_tot.largest_gap    = r_max;
        o_tot.gap_sum        = r_sum;
        for (int k = 0; k < HIST_BINS; k++) begin
            o_hist[k] = OUT_CNT_W'(r_lane[k]);
        end
    end

endmodule

`default_nettype wire

@@ src/ulpes_report.sv @@
// report buffer: frozen totals plus a shift line of bins, one word per cycle while o_rep is ready
// depends on ulpes_pkg and ulpes_if
`timescale 1ns / 1ps
`default_nettype none

module ulpes_report import ulpes_pkg::*; #(
    parameter int HIST_BINS = DEF_HIST_BINS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  t_totals              i_tot,
    input  wire [OUT_CNT_W-1:0]  i_hist [HIST_BINS],
    output logic                 o_free,
    ulpes_out_if.source          o_rep
);

    localparam int NUM_W = $clog2(HIST_BINS + 1);

    logic                 r_busy;
    logic [NUM_W-1:0]     r_num;
    t_totals              r_tot;
    logic [OUT_CNT_W-1:0] r_bins [HIST_BINS];
    logic                 pop;
    logic                 last;

    assign last   = (r_num == NUM_W'(HIST_BINS));
    assign pop    = r_busy && o_rep.ready;
    assign o_free = !r_busy || (pop && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_num  <= NUM_W'(1);
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_num  <= NUM_W'(1);
        end else if (pop) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_num <= r_num + NUM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tot <= i_tot;
            for (int k = 0; k < HIST_BINS; k++) begin
                r_bins[k] <= i_hist[k];
            end
        end else if (pop) begin
            for (int k = 0; k < HIST_BINS - 1; k++) begin
                r_bins[k] <= r_bins[k+1];
            end
        end
    end

    assign o_rep.valid = r_busy;

    always_comb begin
        o_rep.word.pair_total     = r_tot.pair_total;
        o_rep.word.mismatch_total = r_tot.mismatch_total;
        o_rep.word.largest_gap    = r_tot.largest_gap;
        o_rep.word.gap_sum        = r_tot.gap_sum;
        o_rep.word.bin_number     = BIN_NUM_W'(r_num);
        o_rep.word.bin_total      = r_bins[0];
        o_rep.word.final_result   = last;
    end

endmodule

`default_nettype wire

@@ src/ulp_error_statistics.sv @@
// top level of the float64 ulp distance statistics block
// depends on ulpes_pkg, ulpes_if, ulpes_gap_pipe, ulpes_accum, ulpes_report
// and the assertion macros in ulp_error_statistics_defines.svh
//
// usage:
//   i_req carries request words: req_type 0 compares want_bits against got_bits
//   (raw double patterns), req_type 1 is a finish. o_rep carries report words,
//   HIST_BINS of them per finish, bins 1..HIST_BINS in rising order, with
//   final_result set on the last one; the four totals repeat in each word.
// flow:
//   one request word per cycle is taken while no finish is held. a compare
//   passes the input, key and gap registers and is then folded into the
//   statistics registers. the first report word of a finish is valid once the
//   finish leaves the gap registers and loads the report buffer, then one word
//   per cycle while o_rep is ready, so a report is HIST_BINS words long.
// stalls:
//   the report buffer is its own output register, so compares keep flowing
//   while a report drains. a second finish waits in the gap stage, and i_req
//   drops ready, until the buffer hands out its last word.
// reset:
//   synchronous, active low; empties the pipeline and report buffer and clears
//   all counters, the largest gap, the sum and every histogram bin.
`timescale 1ns / 1ps
`default_nettype none
`include "ulp_error_statistics_defines.svh"

module ulp_error_statistics import ulpes_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int HIST_BINS  = DEF_HIST_BINS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ulpes_in_if.sink     i_req,
    ulpes_out_if.source  o_rep
);

    t_gap_item            item;
    t_totals              tot;
    logic [OUT_CNT_W-1:0] hist [HIST_BINS];
    logic                 rep_free;
    logic                 hold;
    logic                 take;
    logic                 take_fin;

    // a finish at the end of the gap stage needs a free report buffer
    assign hold     = item.vld && item.fin && !rep_free;
    assign take     = item.vld && !hold;
    assign take_fin = take && item.fin;

    ulpes_gap_pipe u_gap_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_hold  (hold),
        .o_item  (item)
    );

    // statistics registers, cleared in the cycle the report freezes them
    ulpes_accum #(
        .COUNT_BITS (COUNT_BITS),
        .HIST_BINS  (HIST_BINS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (item),
        .o_tot   (tot),
        .o_hist  (hist)
    );

    // report buffer doubles as the output register
    ulpes_report #(
        .HIST_BINS (HIST_BINS)
    ) u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take_fin),
        .i_tot   (tot),
        .i_hist  (hist),
        .o_free  (rep_free),
        .o_rep   (o_rep)
    );

    // a taken finish opens a report at bin one
    `ULPES_ASSERT_NEXT(a_report_opens, i_clk, i_rst_n, take_fin, o_rep.valid && (o_rep.word.bin_number == BIN_NUM_W'(1)), "report did not open at bin one")

    // the last word drained with no new finish closes the report
    `ULPES_ASSERT_NEXT(a_report_closes, i_clk, i_rst_n, o_rep.valid && o_rep.ready && o_rep.word.final_result && !take_fin, !o_rep.valid, "report still valid after final word")

    // a held finish is still waiting in the gap stage in the next cycle
    `ULPES_ASSERT_NEXT(a_hold_keeps_finish, i_clk, i_rst_n, hold, item.vld && item.fin, "held finish was lost")

    // no request enters while a finish is held
    `ULPES_ASSERT_NOW(a_hold_blocks_input, i_clk, i_rst_n, hold && o_rep.valid, !i_req.ready, "request taken during a held finish")

endmodule

`default_nettype wire

@@ sim/ulp_error_statistics_test.sv @@
// self-checking bench for ulp_error_statistics: ulp gap statistics and finish reports
// depends on ulpes_pkg, ulpes_if and the block itself
`timescale 1ns / 1ps
`default_nettype none

module ulp_error_statistics_test;
    import ulpes_pkg::*;

    localparam int NBINS       = DEF_HIST_BINS;
    localparam int N_RANDOM    = 420;
    localparam int HOLD_AT     = 320;  // words taken before the long output hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 12;   // wait for stray report words after the last owed one

    logic i_clk = 1'b0;
    logic i_rst_n;

    ulpes_in_if  req_ch ();
    ulpes_out_if rep_ch ();

    ulp_error_statistics u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rep   (rep_ch)
    );

    always #6 i_clk = ~i_clk;

    // request words still to be offered, report words still owed by the block
    t_in_word  pending_reqs[$];
    t_out_word owed_reports[$];

    // predicted statistics state
    logic [OUT_CNT_W-1:0] pairs_seen;
    logic [OUT_CNT_W-1:0] pairs_differing;
    logic [GAP_W-1:0]     widest_gap;
    logic [GAP_W-1:0]     gap_total;
    logic [OUT_CNT_W-1:0] bin_count[NBINS];

    int        taken_cnt;
    int        mismatch_cnt;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_left;
    logic      hold_done;
    t_out_word oldest_rep;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic [OUT_CNT_W-1:0] bump(input logic [OUT_CNT_W-1:0] cnt);
        return (cnt == '1) ? cnt : cnt + OUT_CNT_W'(1);
    endfunction

    // doubles ordered as integers: negatives count down from -0, positives up from +0,
    // both zeros on 2^63
    function automatic logic [GAP_W-1:0] ordinal(input logic [GAP_W-1:0] pattern);
        return pattern[GAP_W-1] ? (GAP_W'(0) - pattern) : (pattern | SIGN_BIT);
    endfunction

    function automatic void clear_stats();
        pairs_seen      = '0;
        pairs_differing = '0;
        widest_gap      = '0;
        gap_total       = '0;
        for (int k = 0; k < NBINS; k++) begin
            bin_count[k] = '0;
        end
    endfunction

    // fold one accepted request into the predicted state, queue a report on finish
    function automatic void fold_request(input t_in_word w);
        logic [GAP_W-1:0] ka;
        logic [GAP_W-1:0] kb;
        logic [GAP_W-1:0] gap;
        logic [GAP_W:0]   wide_sum;
        int               bin;
        t_out_word        rep;
        if (w.req_type == REQ_COMPARE) begin
            pairs_seen = bump(pairs_seen);
            if (w.want_bits != w.got_bits) begin
                pairs_differing = bump(pairs_differing);
                ka  = ordinal(w.want_bits);
                kb  = ordinal(w.got_bits);
                gap = (ka > kb) ? ka - kb : kb - ka;
                if (gap > widest_gap) begin
                    widest_gap = gap;
                end
                wide_sum  = {1'b0, gap_total} + {1'b0, gap};
                gap_total = wide_sum[GAP_W] ? '1 : wide_sum[GAP_W-1:0];
                // signed-zero mismatch: gap zero, no bin
                if (gap != '0) begin
                    bin = (gap < GAP_W'(NBINS)) ? int'(gap) : NBINS;
                    bin_count[bin-1] = bump(bin_count[bin-1]);
                end
            end
        end else begin
            for (int k = 0; k < NBINS; k++) begin
                rep.pair_total     = pairs_seen;
                rep.mismatch_total = pairs_differing;
                rep.largest_gap    = widest_gap;
                rep.gap_sum        = gap_total;
                rep.bin_number     = BIN_NUM_W'(k + 1);
                rep.bin_total      = bin_count[k];
                rep.final_result   = (k == NBINS - 1);
                owed_reports.push_back(rep);
            end
            clear_stats();
        end
    endfunction

    // ---------------------------------------------------------------
    // reporting
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [GAP_W-1:0] seen,
                               input logic [GAP_W-1:0] wanted);
        if (seen !== wanted) begin
            note_mismatch($sformatf("%s got %h expected %h", name, seen, wanted));
        end
    endtask

    // ---------------------------------------------------------------
    // idling: sender light / receiver heavy, then swapped, then none
    // ---------------------------------------------------------------

    always_comb begin
        if (taken_cnt < 145) begin
            send_idle_pct = 7;
            recv_idle_pct = 63;
        end else if (taken_cnt < 290) begin
            send_idle_pct = 63;
            recv_idle_pct = 7;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // one long output hold-off while requests keep coming, so a second finish backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && taken_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            taken_cnt    <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                fold_request(req_ch.word);
                void'(pending_reqs.pop_front());
                taken_cnt <= taken_cnt + 1;
            end
            // a word on offer stays put until it is taken
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.word  <= pending_reqs[0];
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // report monitor
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rep_ch.ready <= 1'b0;
        end else begin
            if (rep_ch.valid && rep_ch.ready) begin
                if (owed_reports.size() == 0) begin
                    note_mismatch($sformatf("report word bin %0d with none owed",
                                            rep_ch.word.bin_number));
                end else begin
                    oldest_rep = owed_reports.pop_front();
                    check_field("pair_total", GAP_W'(rep_ch.word.pair_total),
                                GAP_W'(oldest_rep.pair_total));
                    check_field("mismatch_total", GAP_W'(rep_ch.word.mismatch_total),
                                GAP_W'(oldest_rep.mismatch_total));
                    check_field("largest_gap", rep_ch.word.largest_gap,
                                oldest_rep.largest_gap);
                    check_field("gap_sum", rep_ch.word.gap_sum, oldest_rep.gap_sum);
                    check_field("bin_number", GAP_W'(rep_ch.word.bin_number),
                                GAP_W'(oldest_rep.bin_number));
                    check_field("bin_total", GAP_W'(rep_ch.word.bin_total),
                                GAP_W'(oldest_rep.bin_total));
                    check_field("final_result", GAP_W'(rep_ch.word.final_result),
                                GAP_W'(oldest_rep.final_result));
                end
            end
            rep_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic add_pair(input logic [GAP_W-1:0] want, input logic [GAP_W-1:0] got);
        t_in_word w;
        w.req_type  = REQ_COMPARE;
        w.want_bits = want;
        w.got_bits  = got;
        pending_reqs.push_back(w);
    endtask

    // finish words carry junk operands, the block must ignore them
    task automatic add_finish();
        t_in_word w;
        w.req_type  = REQ_FINISH;
        w.want_bits = {$urandom, $urandom};
        w.got_bits  = {$urandom, $urandom};
        pending_reqs.push_back(w);
    endtask

    initial begin
        logic [GAP_W-1:0] base;
        logic [GAP_W-1:0] other;
        int               mode;
        int               delta;

        req_ch.valid = 1'b0;
        req_ch.word  = '0;
        rep_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        mismatch_cnt = 0;
        clear_stats();

        // directed part
        add_finish();                                          // empty report right after reset
        add_pair(64'd0, 64'd0);                                // equal zeros
        add_pair(64'd0, SIGN_BIT);                             // +0 against -0
        add_pair(SIGN_BIT, 64'd0);                             // -0 against +0
        add_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001);  // gap 1
        add_pair(64'd1, SIGN_BIT | 64'd1);                     // across zero, gap 2
        add_pair(64'hC000_0000_0000_0003, 64'hC000_0000_0000_0000);  // negatives, gap 3
        add_pair(64'h4000_0000_0000_0000, 64'h4000_0000_0000_000F);  // last exact bin
        add_pair(64'h4000_0000_0000_0010, 64'h4000_0000_0000_0000);  // overflow bin edge
        add_pair(64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0000);  // nan against inf
        add_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);  // widest possible gap, sum saturates
        add_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);  // reversed pair, sum stays saturated
        add_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);  // equal all ones
        add_finish();
        add_finish();                                          // back-to-back finish
        add_pair(64'd5, 64'd4);
        add_finish();

        // random part: near misses with small gaps, equal pairs, small values around zero, wild pairs and finishes
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(99);
            if (mode < 5) begin
                add_finish();
            end else if (mode == 5) begin
                add_finish();
                add_finish();
            end else if (mode < 50) begin
                base  = {$urandom, $urandom};
                delta = $urandom_range(20);
                other = $urandom_range(1) ? base + GAP_W'(delta) : base - GAP_W'(delta);
                add_pair(base, other);
            end else if (mode < 65) begin
                base = {$urandom, $urandom};
                add_pair(base, base);
            end else if (mode < 78) begin
                // small magnitudes either side of zero
                base  = GAP_W'($urandom_range(12));
                other = GAP_W'($urandom_range(12));
                base[GAP_W-1]  = 1'($urandom_range(1));
                other[GAP_W-1] = 1'($urandom_range(1));
                add_pair(base, other);
            end else begin
                add_pair({$urandom, $urandom}, {$urandom, $urandom});
            end
        end
        add_finish();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0) begin
            @(posedge i_clk);
        end
        while (owed_reports.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray report words
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
